/* sv/fxaa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the edge anti-aliasing block.
package fxaa_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CRD_W  = 11;   // signed coordinate, covers taps past the frame edges
    localparam int LUMA_W = 18;
    localparam int DIR_W  = 21;
    localparam int ABS_W  = 20;
    localparam int RED_W  = 24;
    localparam int DEN_W  = 28;
    localparam int NUM_W  = 32;
    localparam int DIV_W  = 40;
    localparam int QUO_W  = 8;
    localparam int D_W    = 9;
    localparam int CNT_W  = 3;

    localparam logic [RED_W-1:0] RED_MIN   = RED_W'(255000);
    localparam logic [QUO_W-1:0] D_LIMIT   = QUO_W'(192);
    localparam logic [8:0]       FW_RESET  = 9'd256;
    localparam logic [8:0]       FH_RESET  = 9'd256;
    localparam logic [17:0]      CTH_RESET = 18'd20400;
    localparam logic [17:0]      DTH_RESET = 18'd255;

    localparam logic [CNT_W-1:0] NUM_CROSS  = CNT_W'(5);
    localparam logic [CNT_W-1:0] NUM_CORNER = CNT_W'(4);
    localparam logic [CNT_W-1:0] NUM_TAP    = CNT_W'(4);

    typedef logic signed [CRD_W-1:0] t_crd;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_FILTER = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CONTRAST = 2'd2,
        CFG_DARK     = 2'd3
    } t_cfg;

    typedef enum logic [1:0] {
        PATH_LOW  = 2'd0,
        PATH_DARK = 2'd1,
        PATH_TWO  = 2'd2,
        PATH_FOUR = 2'd3
    } t_path;

    // Read slots: centre, cross, corners, then the four blend taps.
    typedef enum logic [3:0] {
        IDX_C  = 4'd0,
        IDX_N  = 4'd1,
        IDX_S  = 4'd2,
        IDX_E  = 4'd3,
        IDX_W  = 4'd4,
        IDX_NW = 4'd5,
        IDX_NE = 4'd6,
        IDX_SW = 4'd7,
        IDX_SE = 4'd8,
        IDX_T0 = 4'd9,
        IDX_T1 = 4'd10,
        IDX_T2 = 4'd11,
        IDX_T3 = 4'd12
    } t_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_RD_CROSS,
        S_DECIDE,
        S_BRANCH,
        S_RD_CORNER,
        S_DIR,
        S_DIVX,
        S_WAITX,
        S_DIVY,
        S_WAITY,
        S_RD_TAP,
        S_BLEND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic setup;
        logic rd_en;
        t_idx rd_idx;
        logic decide;
        logic dir;
        logic div_start;
        logic div_k;
        logic blend;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [LUMA_W-1:0] luma(input logic [23:0] c);
        logic [LUMA_W-1:0] r;
        logic [LUMA_W-1:0] g;
        logic [LUMA_W-1:0] b;
        r = {10'b0, c[23:16]};
        g = {10'b0, c[15:8]};
        b = {10'b0, c[7:0]};
        return LUMA_W'(299) * r + LUMA_W'(587) * g + LUMA_W'(114) * b;
    endfunction

    function automatic t_crd clamp_crd(input t_crd v, input t_crd hi);
        t_crd res;
        res = v;
        if (v < 0) res = '0;
        else if (v > hi) res = hi;
        return res;
    endfunction

endpackage

/* sv/fxaa_div.sv */
`timescale 1ns / 1ps
// Restoring divider for the rounded, saturated direction ratio, one quotient bit a cycle.
module fxaa_div
    import fxaa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [9:0]        r_q;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd9;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Rounding is folded in: the dividend is 2*num + den over a divisor of 2*den.
    // The first step tests 512 times the divisor and only marks saturation.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'({i_num, 1'b0}) + DIV_W'(i_den);
            r_dsh <= DIV_W'({i_den, 10'b0});
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[8:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q[9] || r_q[8:0] > {1'b0, D_LIMIT}) ? D_LIMIT : r_q[7:0];

endmodule

/* sv/fxaa_dp.sv */
`timescale 1ns / 1ps
// Datapath: frame memory, configuration registers, luma, direction and blend arithmetic.
module fxaa_dp
    import fxaa_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_op,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [23:0] i_pixel_color,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_filtered_color,
    output logic [1:0]  o_path_taken
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [8:0]  r_fw;
    logic [8:0]  r_fh;
    logic [17:0] r_cth;
    logic [17:0] r_dth;

    logic [7:0]  r_px;
    logic [7:0]  r_py;
    t_crd        r_x, r_y, r_xl, r_xr, r_yu, r_yd, r_wm1, r_hm1;
    t_crd        wm1, hm1, cx, cy, sx, sy;

    logic [23:0] mem [DEPTH];
    logic [23:0] r_q;
    logic        r_qv;
    t_idx        r_qidx;
    logic [23:0] r_col [13];

    logic [LUMA_W-1:0] r_lmin, r_lmax;
    logic              r_pass;
    logic [23:0]       r_res;
    t_path             r_path;

    logic signed [DIR_W-1:0] r_dirx, r_diry;
    logic [DEN_W-1:0]        r_den;
    logic signed [D_W-1:0]   r_dx, r_dy;

    logic [23:0] r_out_color;
    t_path       r_out_path;
    logic        r_out_valid;

    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [LUMA_W-1:0] lc, ln, ls, le, lw, mx, mn;
    logic [LUMA_W-1:0] lnw, lne, lsw, lse;
    logic [LUMA_W:0]   s_n, s_s, s_w, s_e;
    logic [LUMA_W+1:0] s_all;
    logic [RED_W-1:0]  red;
    logic signed [DIR_W-1:0] dirx, diry, dsel;
    logic [ABS_W-1:0]  ax, ay, amin, asel;
    logic              div_done;
    logic [QUO_W-1:0]  quot;
    logic [23:0]       blend_a, blend_b;
    logic [LUMA_W-1:0] lb;

    // Tap offset along one axis: round-half-away division by 96 or 32.
    function automatic t_crd tap_off(input logic signed [D_W-1:0] d, input logic [1:0] t);
        logic [7:0] m;
        logic [8:0] s;
        logic [2:0] q;
        logic       neg;
        m = d[D_W-1] ? 8'(-d) : 8'(d);
        q = '0;
        if (!t[1]) begin
            s = {1'b0, m} + 9'd48;
            if (s >= 9'd192) q = 3'd2;
            else if (s >= 9'd96) q = 3'd1;
        end else begin
            s = {1'b0, m} + 9'd16;
            q = s[7:5];
        end
        neg = (!t[0]) ^ d[D_W-1];
        return neg ? -$signed({8'b0, q}) : $signed({8'b0, q});
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= FW_RESET;
            r_fh  <= FH_RESET;
            r_cth <= CTH_RESET;
            r_dth <= DTH_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_WIDTH:    r_fw  <= i_cfg_data[8:0];
                CFG_HEIGHT:   r_fh  <= i_cfg_data[8:0];
                CFG_CONTRAST: r_cth <= i_cfg_data;
                CFG_DARK:     r_dth <= i_cfg_data;
                default:      r_dth <= r_dth;
            endcase
        end
    end

    // Frame size in use, saturated into the store.
    always_comb begin
        if (r_fw == 9'd0) wm1 = '0;
        else if (int'(r_fw) > MAX_WIDTH) wm1 = CRD_W'(MAX_WIDTH - 1);
        else wm1 = $signed({2'b00, r_fw}) - 11'sd1;
        if (r_fh == 9'd0) hm1 = '0;
        else if (int'(r_fh) > MAX_HEIGHT) hm1 = CRD_W'(MAX_HEIGHT - 1);
        else hm1 = $signed({2'b00, r_fh}) - 11'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (i_cmd.setup) begin
            r_wm1 <= wm1;
            r_hm1 <= hm1;
            r_x   <= clamp_crd($signed({3'b000, r_px}), wm1);
            r_y   <= clamp_crd($signed({3'b000, r_py}), hm1);
            // Left and upper neighbours step back from the already clamped centre.
            r_xl  <= clamp_crd(clamp_crd($signed({3'b000, r_px}), wm1) - 11'sd1, wm1);
            r_xr  <= clamp_crd($signed({3'b000, r_px}) + 11'sd1, wm1);
            r_yu  <= clamp_crd(clamp_crd($signed({3'b000, r_py}), hm1) - 11'sd1, hm1);
            r_yd  <= clamp_crd($signed({3'b000, r_py}) + 11'sd1, hm1);
        end
    end

    // Neighbour and tap coordinates. The x and y of a clamped coordinate stay
    // inside the frame, so the address never leaves the store.
    always_comb begin
        sx = clamp_crd(r_x + tap_off(r_dx, 2'(i_cmd.rd_idx - IDX_T0)), r_wm1);
        sy = clamp_crd(r_y + tap_off(r_dy, 2'(i_cmd.rd_idx - IDX_T0)), r_hm1);
        unique case (i_cmd.rd_idx)
            IDX_C:  begin cx = r_x;  cy = r_y;  end
            IDX_N:  begin cx = r_x;  cy = r_yu; end
            IDX_S:  begin cx = r_x;  cy = r_yd; end
            IDX_E:  begin cx = r_xr; cy = r_y;  end
            IDX_W:  begin cx = r_xl; cy = r_y;  end
            IDX_NW: begin cx = r_xl; cy = r_yu; end
            IDX_NE: begin cx = r_xr; cy = r_yu; end
            IDX_SW: begin cx = r_xl; cy = r_yd; end
            IDX_SE: begin cx = r_xr; cy = r_yd; end
            IDX_T0, IDX_T1, IDX_T2, IDX_T3: begin cx = sx; cy = sy; end
            default: begin cx = r_x; cy = r_y; end
        endcase
    end

    assign rd_addr = AW'(int'(cy) * MAX_WIDTH + int'(cx));
    assign wr_ok   = (int'(i_pos_x) < MAX_WIDTH) && (int'(i_pos_y) < MAX_HEIGHT);
    assign wr_addr = AW'(int'(i_pos_y) * MAX_WIDTH + int'(i_pos_x));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && t_op'(i_op) == OP_WRITE && wr_ok) mem[wr_addr] <= i_pixel_color;
        if (i_cmd.rd_en) r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv   <= 1'b0;
            r_qidx <= IDX_C;
        end else begin
            r_qv   <= i_cmd.rd_en;
            r_qidx <= i_cmd.rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_qv) r_col[r_qidx] <= r_q;
    end

    // Contrast and dark tests over the centre and its cross.
    always_comb begin
        lc = luma(r_col[IDX_C]);
        ln = luma(r_col[IDX_N]);
        ls = luma(r_col[IDX_S]);
        le = luma(r_col[IDX_E]);
        lw = luma(r_col[IDX_W]);
        mx = lc;
        mn = lc;
        if (ln > mx) mx = ln;
        if (ls > mx) mx = ls;
        if (le > mx) mx = le;
        if (lw > mx) mx = lw;
        if (ln < mn) mn = ln;
        if (ls < mn) mn = ls;
        if (le < mn) mn = le;
        if (lw < mn) mn = lw;
    end

    // Edge direction and the reduced denominator.
    always_comb begin
        lnw   = luma(r_col[IDX_NW]);
        lne   = luma(r_col[IDX_NE]);
        lsw   = luma(r_col[IDX_SW]);
        lse   = luma(r_col[IDX_SE]);
        s_n   = {1'b0, lnw} + {1'b0, lne};
        s_s   = {1'b0, lsw} + {1'b0, lse};
        s_w   = {1'b0, lnw} + {1'b0, lsw};
        s_e   = {1'b0, lne} + {1'b0, lse};
        s_all = {1'b0, s_n} + {1'b0, s_s};
        red   = {s_all, 4'b0};
        if (red < RED_MIN) red = RED_MIN;
        dirx  = $signed({2'b00, s_s}) - $signed({2'b00, s_n});
        diry  = $signed({2'b00, s_w}) - $signed({2'b00, s_e});
        ax    = dirx[DIR_W-1] ? ABS_W'(-dirx) : ABS_W'(dirx);
        ay    = diry[DIR_W-1] ? ABS_W'(-diry) : ABS_W'(diry);
        amin  = (ax < ay) ? ax : ay;
        dsel  = i_cmd.div_k ? r_diry : r_dirx;
        asel  = dsel[DIR_W-1] ? ABS_W'(-dsel) : ABS_W'(dsel);
    end

    fxaa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({asel, 12'b0}),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Two-tap and four-tap averages, one channel at a time.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [8:0] sa;
            logic [9:0] sb;
            sa = {1'b0, r_col[IDX_T0][8*ch +: 8]} + {1'b0, r_col[IDX_T1][8*ch +: 8]};
            blend_a[8*ch +: 8] = sa[8:1];
            sb = {1'b0, sa[8:1], 1'b0} + {2'b00, r_col[IDX_T2][8*ch +: 8]}
               + {2'b00, r_col[IDX_T3][8*ch +: 8]};
            blend_b[8*ch +: 8] = sb[9:2];
        end
        lb = luma(blend_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_lmin <= mn;
            r_lmax <= mx;
            r_res  <= r_col[IDX_C];
            if ((mx - mn) < r_cth) begin
                r_pass <= 1'b1;
                r_path <= PATH_LOW;
            end else if (lc < r_dth) begin
                r_pass <= 1'b1;
                r_path <= PATH_DARK;
            end else begin
                r_pass <= 1'b0;
                r_path <= PATH_FOUR;
            end
        end
        if (i_cmd.dir) begin
            r_dirx <= dirx;
            r_diry <= diry;
            r_den  <= {amin, 8'b0} + DEN_W'(red);
        end
        if (div_done) begin
            if (i_cmd.div_k) r_dy <= dsel[DIR_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
            else             r_dx <= dsel[DIR_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        end
        if (i_cmd.blend) begin
            if (lb < r_lmin || lb > r_lmax) begin
                r_res  <= blend_a;
                r_path <= PATH_TWO;
            end else begin
                r_res  <= blend_b;
                r_path <= PATH_FOUR;
            end
        end
    end

    // Output register lets the next request in while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_color <= r_res;
            r_out_path  <= r_path;
        end
    end

    assign o_sts.pass     = r_pass;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_filtered_color = r_out_color;
    assign o_path_taken     = r_out_path;

endmodule

/* sv/fxaa_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences memory reads, decisions, divisions and blending.
module fxaa_ctrl
    import fxaa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_op,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = '0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && t_op'(i_op) == OP_FILTER) n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_RD_CROSS;
            end
            S_RD_CROSS: begin
                o_cmd.rd_en  = (r_cnt < NUM_CROSS);
                o_cmd.rd_idx = t_idx'(4'(IDX_C) + 4'(r_cnt));
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == NUM_CROSS) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_BRANCH;
            end
            S_BRANCH: begin
                n_state = i_sts.pass ? S_OUT : S_RD_CORNER;
            end
            S_RD_CORNER: begin
                o_cmd.rd_en  = (r_cnt < NUM_CORNER);
                o_cmd.rd_idx = t_idx'(4'(IDX_NW) + 4'(r_cnt));
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == NUM_CORNER) n_state = S_DIR;
            end
            S_DIR: begin
                o_cmd.dir = 1'b1;
                n_state   = S_DIVX;
            end
            S_DIVX: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAITX;
            end
            S_WAITX: begin
                if (i_sts.div_done) n_state = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_k     = 1'b1;
                n_state         = S_WAITY;
            end
            S_WAITY: begin
                o_cmd.div_k = 1'b1;
                if (i_sts.div_done) n_state = S_RD_TAP;
            end
            S_RD_TAP: begin
                o_cmd.rd_en  = (r_cnt < NUM_TAP);
                o_cmd.rd_idx = t_idx'(4'(IDX_T0) + 4'(r_cnt));
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == NUM_TAP) n_state = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* sv/fxaa_edge_antialias_top.sv */
`timescale 1ns / 1ps
// A write request is stored in the frame memory as it is accepted. A filter request that
// passes unchanged makes the five cross reads; one that blends also makes the four corner
// reads, the x and y direction divisions and the four tap reads. One request is in work at
// a time; a finished result waits in the output register while the next request is taken.
// Synchronous active-low reset clears control state and loads the register defaults;
// the frame memory is not cleared.
module fxaa_edge_antialias_top
    import fxaa_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [23:0] i_pixel_color,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_filtered_color,
    output logic [1:0]  o_path_taken
);

    t_cmd cmd;
    t_sts sts;

    fxaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fxaa_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (i_op),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pixel_color    (i_pixel_color),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_color (o_filtered_color),
        .o_path_taken     (o_path_taken)
    );

endmodule
